// ===== rtl/fsq_pkg.sv =====
package fsq_pkg;

   // sizes of the slot array and of each slot's step table
   localparam int NUM_SLOTS = 16;
   localparam int NUM_STEPS = 18;

   // field widths fixed by the item format
   localparam int SLOT_W  = 4;
   localparam int STEP_W  = 5;
   localparam int FRAME_W = 8;
   localparam int HOLD_W  = 8;
   localparam int ENTRY_W = FRAME_W + HOLD_W;

   // derived storage sizes
   localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int TABLE_DEPTH = NUM_SLOTS * NUM_STEPS;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // frame value that marks the end of a sequence
   localparam logic [FRAME_W-1:0] END_MARK = 8'hff;

   // request codes
   localparam logic [1:0] REQ_WRITE    = 2'd0;
   localparam logic [1:0] REQ_TICK     = 2'd1;
   localparam logic [1:0] REQ_ACTIVATE = 2'd2;
   localparam logic [1:0] REQ_RELEASE  = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [SLOT_W-1:0]  slot;
      logic [STEP_W-1:0]  step;
      logic [FRAME_W-1:0] frame_in;
      logic [HOLD_W-1:0]  hold_in;
   } fsq_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  out_slot;
      logic [FRAME_W-1:0] out_frame;
      logic               last;
   } fsq_rsp_type;

   // operations on the per-slot registers
   typedef enum logic [1:0] {
      SLOT_NOP,
      SLOT_ACTIVATE,
      SLOT_RELEASE,
      SLOT_UPDATE
   } fsq_slot_op_type;

   typedef struct packed {
      fsq_slot_op_type       op;
      logic [SLOT_IDX_W-1:0] idx;
      logic [STEP_W-1:0]     cur_step;
      logic [HOLD_W-1:0]     hold_count;
   } fsq_slot_ctl_type;

   typedef struct packed {
      logic              active;
      logic [STEP_W-1:0] cur_step;
      logic [HOLD_W-1:0] hold_count;
   } fsq_slot_view_type;

   // tick sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_RD_NEXT,
      ST_RD_ZERO,
      ST_EVAL,
      ST_FLUSH
   } fsq_state_type;

endpackage

// ===== rtl/fsq_ram.sv =====
module fsq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/fsq_slot_regs.sv =====
module fsq_slot_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fsq_pkg::fsq_slot_ctl_type            ctl,
   input  logic [fsq_pkg::SLOT_IDX_W-1:0]       rd_idx,
   output fsq_pkg::fsq_slot_view_type           view
);

   logic                          active_ff [fsq_pkg::NUM_SLOTS];
   logic [fsq_pkg::STEP_W-1:0]    step_ff   [fsq_pkg::NUM_SLOTS];
   logic [fsq_pkg::HOLD_W-1:0]    count_ff  [fsq_pkg::NUM_SLOTS];

   // per-slot active bit, current step and hold counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fsq_pkg::NUM_SLOTS; i++) begin
            active_ff[i] <= 1'b0;
            step_ff[i]   <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         unique case (ctl.op)
            fsq_pkg::SLOT_NOP: begin
            end
            fsq_pkg::SLOT_ACTIVATE: begin
               active_ff[ctl.idx] <= 1'b1;
            end
            fsq_pkg::SLOT_RELEASE: begin
               active_ff[ctl.idx] <= 1'b0;
               step_ff[ctl.idx]   <= '0;
               count_ff[ctl.idx]  <= '0;
            end
            fsq_pkg::SLOT_UPDATE: begin
               step_ff[ctl.idx]  <= ctl.cur_step;
               count_ff[ctl.idx] <= ctl.hold_count;
            end
            default: begin
            end
         endcase
      end
   end

   // view of the slot under scan
   assign view.active     = active_ff[rd_idx];
   assign view.cur_step   = step_ff[rd_idx];
   assign view.hold_count = count_ff[rd_idx];

endmodule

// ===== rtl/multi_slot_frame_sequencer.sv =====
// Keyframe sequencer for 16 animation slots, each with an 18-step table of
// frame and hold pairs. An item is taken when start is high and busy is low.
// Write, activate and release items finish in the cycle they are taken. A
// tick keeps busy high while it scans every slot: each active slot needs three
// reads through the single read port of the step table (current step, next
// step, step zero) and an evaluate state. Each result is on rsp_item for a
// single cycle with rsp_valid high, in ascending slot order; the final one of
// a tick carries last and appears in the same cycle that busy falls. The
// receiver cannot stall, so rsp_item must be taken in the cycle rsp_valid is
// high. Table entries that were never written must not be reached by a tick.
module multi_slot_frame_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fsq_pkg::fsq_req_type req_item,
   output logic                 rsp_valid,
   output fsq_pkg::fsq_rsp_type rsp_item
);

   fsq_pkg::fsq_state_type              state_ff, state_in;
   logic [fsq_pkg::SLOT_IDX_W-1:0]      idx_ff, idx_in;
   logic [fsq_pkg::ADDR_W-1:0]          base_ff, base_in;
   logic [fsq_pkg::HOLD_W-1:0]          ent_hold_ff, ent_hold_in;
   logic [fsq_pkg::FRAME_W-1:0]         nxt_frame_ff, nxt_frame_in;
   logic                                pend_valid_ff, pend_valid_in;
   logic [fsq_pkg::SLOT_IDX_W-1:0]      pend_slot_ff, pend_slot_in;
   logic [fsq_pkg::FRAME_W-1:0]         pend_frame_ff, pend_frame_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   fsq_pkg::fsq_rsp_type                rsp_ff, rsp_in;

   logic                                accept;
   logic                                slot_ok;
   logic                                wr_en;
   logic [fsq_pkg::ADDR_W-1:0]          wr_addr;
   logic [fsq_pkg::ADDR_W-1:0]          rd_addr;
   logic [fsq_pkg::ENTRY_W-1:0]         rd_data;
   logic [fsq_pkg::ADDR_W-1:0]          cur_addr;
   logic [fsq_pkg::ADDR_W-1:0]          next_addr;
   logic                                next_in_range;
   logic                                wrap;
   logic                                last_idx;
   logic [fsq_pkg::STEP_W-1:0]          step_plus;
   fsq_pkg::fsq_state_type              after_state;
   fsq_pkg::fsq_slot_ctl_type           slot_ctl;
   fsq_pkg::fsq_slot_view_type          view;

   assign accept  = start && !busy;
   assign slot_ok = (32'(req_item.slot) < fsq_pkg::NUM_SLOTS);

   // table writes straight from the request while idle
   assign wr_en   = accept && (req_item.req_type == fsq_pkg::REQ_WRITE) && slot_ok
                    && (32'(req_item.step) < fsq_pkg::NUM_STEPS);
   assign wr_addr = fsq_pkg::ADDR_W'(32'(req_item.slot) * fsq_pkg::NUM_STEPS)
                    + fsq_pkg::ADDR_W'(req_item.step);

   fsq_ram #(
      .WIDTH (fsq_pkg::ENTRY_W),
      .DEPTH (fsq_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_item.hold_in, req_item.frame_in}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fsq_slot_regs u_slots (
      .clock  (clock),
      .reset  (reset),
      .ctl    (slot_ctl),
      .rd_idx (idx_ff),
      .view   (view)
   );

   // addresses and step arithmetic for the slot under scan
   assign cur_addr      = base_ff + fsq_pkg::ADDR_W'(view.cur_step);
   assign next_in_range = (32'(view.cur_step) < (fsq_pkg::NUM_STEPS - 1));
   assign next_addr     = next_in_range ? (cur_addr + fsq_pkg::ADDR_W'(1)) : base_ff;
   assign step_plus     = view.cur_step + fsq_pkg::STEP_W'(1);
   assign wrap          = !next_in_range || (nxt_frame_ff == fsq_pkg::END_MARK);
   assign last_idx      = (idx_ff == fsq_pkg::SLOT_IDX_W'(fsq_pkg::NUM_SLOTS - 1));
   assign after_state   = last_idx ? fsq_pkg::ST_FLUSH : fsq_pkg::ST_RD_CUR;

   // tick sequencer next state and outputs
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      base_in       = base_ff;
      ent_hold_in   = ent_hold_ff;
      nxt_frame_in  = nxt_frame_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_frame_in = pend_frame_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr       = base_ff;
      slot_ctl.op         = fsq_pkg::SLOT_NOP;
      slot_ctl.idx        = idx_ff;
      slot_ctl.cur_step   = view.cur_step;
      slot_ctl.hold_count = view.hold_count;

      unique case (state_ff)
         fsq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_item.req_type)
                  fsq_pkg::REQ_TICK: begin
                     state_in = fsq_pkg::ST_RD_CUR;
                     idx_in   = '0;
                     base_in  = '0;
                  end
                  fsq_pkg::REQ_ACTIVATE: begin
                     if (slot_ok) begin
                        slot_ctl.op  = fsq_pkg::SLOT_ACTIVATE;
                        slot_ctl.idx = fsq_pkg::SLOT_IDX_W'(req_item.slot);
                     end
                  end
                  fsq_pkg::REQ_RELEASE: begin
                     if (slot_ok) begin
                        slot_ctl.op  = fsq_pkg::SLOT_RELEASE;
                        slot_ctl.idx = fsq_pkg::SLOT_IDX_W'(req_item.slot);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         fsq_pkg::ST_RD_CUR: begin
            rd_addr = cur_addr;
            if (view.active) begin
               state_in = fsq_pkg::ST_RD_NEXT;
            end else begin
               state_in = after_state;
               idx_in   = idx_ff + fsq_pkg::SLOT_IDX_W'(1);
               base_in  = base_ff + fsq_pkg::ADDR_W'(fsq_pkg::NUM_STEPS);
            end
         end
         fsq_pkg::ST_RD_NEXT: begin
            rd_addr     = next_addr;
            ent_hold_in = rd_data[fsq_pkg::ENTRY_W-1:fsq_pkg::FRAME_W];
            state_in    = fsq_pkg::ST_RD_ZERO;
         end
         fsq_pkg::ST_RD_ZERO: begin
            rd_addr      = base_ff;
            nxt_frame_in = rd_data[fsq_pkg::FRAME_W-1:0];
            state_in     = fsq_pkg::ST_EVAL;
         end
         fsq_pkg::ST_EVAL: begin
            slot_ctl.op = fsq_pkg::SLOT_UPDATE;
            if (ent_hold_ff <= view.hold_count) begin
               // hold expired: advance, wrap at marker or table end
               slot_ctl.cur_step   = wrap ? '0 : step_plus;
               slot_ctl.hold_count = '0;
               if (pend_valid_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.out_slot    = fsq_pkg::SLOT_W'(pend_slot_ff);
                  rsp_in.out_frame   = pend_frame_ff;
                  rsp_in.last        = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = idx_ff;
               pend_frame_in = wrap ? rd_data[fsq_pkg::FRAME_W-1:0] : nxt_frame_ff;
            end else begin
               slot_ctl.hold_count = view.hold_count + fsq_pkg::HOLD_W'(1);
            end
            state_in = after_state;
            idx_in   = idx_ff + fsq_pkg::SLOT_IDX_W'(1);
            base_in  = base_ff + fsq_pkg::ADDR_W'(fsq_pkg::NUM_STEPS);
         end
         fsq_pkg::ST_FLUSH: begin
            // held-back result is the final one of the tick
            if (pend_valid_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_slot  = fsq_pkg::SLOT_W'(pend_slot_ff);
               rsp_in.out_frame = pend_frame_ff;
               rsp_in.last      = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = fsq_pkg::ST_IDLE;
         end
         default: begin
            state_in = fsq_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fsq_pkg::ST_IDLE;
         idx_ff        <= '0;
         base_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         base_ff       <= base_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ent_hold_ff   <= ent_hold_in;
      nxt_frame_ff  <= nxt_frame_in;
      pend_slot_ff  <= pend_slot_in;
      pend_frame_ff <= pend_frame_in;
      rsp_ff        <= rsp_in;
   end

   assign busy      = (state_ff != fsq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
